// ----- hdl/krdc_pkg.sv -----
// Shared types and constants for the keystream record decrypt and check block.
package krdc_pkg;

  localparam int unsigned BLOCK_LEN = 32;
  localparam int unsigned POS_W     = $clog2(BLOCK_LEN);
  localparam int unsigned WEIGHT_W  = POS_W + 1;

  localparam logic [31:0] LEN_XOR = 32'hc92e568f;
  localparam logic [31:0] KEY_ADD = 32'ha3b376c9;

  localparam logic [2:0] HDR_LAST = 3'd7;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);
  localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = WEIGHT_W'(BLOCK_LEN);

  typedef enum logic [2:0] {
    EV_HEADER_BYTE = 3'd0,
    EV_HEADER_DONE = 3'd1,
    EV_DATA_BYTE   = 3'd2,
    EV_CHECK_BYTE  = 3'd3,
    EV_CHECK_OK    = 3'd4,
    EV_CHECK_FAIL  = 3'd5
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  plain_byte;
    logic [28:0] record_size;
    logic        end_of_record;
  } res_t;

  function automatic logic [31:0] key_step(input logic [31:0] k);
    key_step = ~({k[30:0], 1'b0} + KEY_ADD + {31'd0, k[15]});
  endfunction

endpackage

// ----- hdl/krdc_if.sv -----
// Channel interfaces: input byte, result, and start key write.
interface krdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  modport source (output valid, output raw_byte, input ready);
  modport sink (input valid, input raw_byte, output ready);
endinterface

interface krdc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  plain_byte;
  logic [28:0] record_size;
  logic        end_of_record;
  modport source (output valid, output event_res, output plain_byte, output record_size,
                  output end_of_record, input ready);
  modport sink (input valid, input event_res, input plain_byte, input record_size,
                input end_of_record, output ready);
endinterface

interface krdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_key;
  modport source (output valid, output start_key, input ready);
  modport sink (input valid, input start_key, output ready);
endinterface

// ----- hdl/krdc_core.sv -----
// Record state, keystream, block sum and per-byte result logic.
module krdc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       raw_byte,
  input  logic [31:0]      start_key,
  output krdc_pkg::res_t   res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_CHK_LO = 2'd2,
    PH_CHK_HI = 2'd3
  } phase_t;

  phase_t                       phase, phase_next;
  logic [2:0]                   header_count, header_count_next;
  logic [31:0]                  length_shift, length_shift_next;
  logic [28:0]                  bytes_left, bytes_left_next;
  logic [krdc_pkg::POS_W-1:0]   block_position, block_position_next;
  logic [31:0]                  key_reg, key_reg_next;
  logic [15:0]                  block_sum, block_sum_next;
  logic [7:0]                   check_low, check_low_next;

  logic [28:0]                  size;
  logic [7:0]                   plain;
  logic [krdc_pkg::WEIGHT_W-1:0] weight;
  logic [krdc_pkg::WEIGHT_W+7:0] product;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    length_shift_next   = length_shift;
    bytes_left_next     = bytes_left;
    block_position_next = block_position;
    key_reg_next        = key_reg;
    block_sum_next      = block_sum;
    check_low_next      = check_low;

    size    = 29'((length_shift_next ^ krdc_pkg::LEN_XOR) >> 3);
    plain   = raw_byte ^ key_reg[7:0];
    weight  = krdc_pkg::WEIGHT_TOP - {1'b0, block_position};
    product = {{(krdc_pkg::WEIGHT_W){1'b0}}, plain} * {8'd0, weight};

    res.event_res     = krdc_pkg::EV_HEADER_BYTE;
    res.plain_byte    = 8'd0;
    res.record_size   = 29'd0;
    res.end_of_record = 1'b0;

    case (phase)
      PH_HEADER: begin
        length_shift_next = {raw_byte, length_shift[31:8]};
        size = 29'((length_shift_next ^ krdc_pkg::LEN_XOR) >> 3);
        if (header_count != krdc_pkg::HDR_LAST) begin
          header_count_next = header_count + 3'd1;
        end else begin
          header_count_next   = 3'd0;
          bytes_left_next     = size;
          key_reg_next        = start_key;
          block_sum_next      = 16'd0;
          block_position_next = '0;
          phase_next          = (size == 29'd0) ? PH_HEADER : PH_DATA;
          res.event_res       = krdc_pkg::EV_HEADER_DONE;
          res.record_size     = size;
          res.end_of_record   = (size == 29'd0);
        end
      end
      PH_DATA: begin
        block_sum_next  = block_sum + 16'(product);
        key_reg_next    = krdc_pkg::key_step(key_reg);
        bytes_left_next = bytes_left - 29'd1;
        res.event_res   = krdc_pkg::EV_DATA_BYTE;
        res.plain_byte  = plain;
        if (block_position == krdc_pkg::POS_LAST) begin
          block_position_next = '0;
          phase_next          = PH_CHK_LO;
        end else begin
          block_position_next = block_position + {{(krdc_pkg::POS_W-1){1'b0}}, 1'b1};
          if (bytes_left_next == 29'd0) begin
            phase_next        = PH_HEADER;
            res.end_of_record = 1'b1;
          end
        end
      end
      PH_CHK_LO: begin
        check_low_next = raw_byte;
        phase_next     = PH_CHK_HI;
        res.event_res  = krdc_pkg::EV_CHECK_BYTE;
      end
      PH_CHK_HI: begin
        block_sum_next      = 16'd0;
        block_position_next = '0;
        if ({raw_byte, check_low} != block_sum) begin
          phase_next      = PH_HEADER;
          bytes_left_next = 29'd0;
          res.event_res   = krdc_pkg::EV_CHECK_FAIL;
        end else begin
          res.event_res = krdc_pkg::EV_CHECK_OK;
          if (bytes_left == 29'd0) begin
            phase_next        = PH_HEADER;
            res.end_of_record = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= 3'd0;
      length_shift   <= 32'd0;
      bytes_left     <= 29'd0;
      block_position <= '0;
      key_reg        <= 32'd0;
      block_sum      <= 16'd0;
      check_low      <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      length_shift   <= length_shift_next;
      bytes_left     <= bytes_left_next;
      block_position <= block_position_next;
      key_reg        <= key_reg_next;
      block_sum      <= block_sum_next;
      check_low      <= check_low_next;
    end
  end

endmodule

// ----- hdl/keystream_record_decrypt_check.sv -----
// Top level: input byte register, record core, result register, start key register.
// An accepted byte waits in the input byte register; its result (core key step and
// weighted sum) is registered as the byte advances. Throughput: one byte per cycle
// unless out_ch stalls; input and result registers form a two-stage pipeline.
// Reset (synchronous, rst high): empties both stages, start key and all record state
// go to zero, the block waits for the first header byte.
module keystream_record_decrypt_check (
  input  logic         clk,
  input  logic         rst,
  krdc_in_if.sink      in_ch,
  krdc_out_if.source   out_ch,
  krdc_cfg_if.sink     cfg
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 out_valid;
  krdc_pkg::res_t       out_res;
  logic [31:0]          start_key;
  logic                 advance;
  krdc_pkg::res_t       res;

  assign advance      = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  krdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .raw_byte  (in_byte),
    .start_key (start_key),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      start_key <= 32'd0;
    end else begin
      if (cfg.valid) begin
        start_key <= cfg.start_key;
      end
      if (in_ch.valid && in_ch.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.raw_byte;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.event_res     = out_res.event_res;
  assign out_ch.plain_byte    = out_res.plain_byte;
  assign out_ch.record_size   = out_res.record_size;
  assign out_ch.end_of_record = out_res.end_of_record;

endmodule

// ----- verif/keystream_record_decrypt_check_tb.sv -----
// Self-checking testbench for the keystream record decrypt and check block.
`timescale 1ns / 100ps

module keystream_record_decrypt_check_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_CHK_LO, PH_CHK_HI} stream_phase_t;

  class record_tracker;
    logic [31:0]      start_key;
    stream_phase_t    phase;
    logic [2:0]       header_count;
    logic [31:0]      length_shift;
    logic [28:0]      bytes_left;
    logic [4:0]       block_position;
    logic [31:0]      key_reg;
    logic [15:0]      block_sum;
    logic [7:0]       check_low;
    krdc_pkg::res_t   pending_results[$];
    int unsigned      error_count;

    function new();
      start_key = '0;
      phase = PH_HEADER;
      header_count = '0;
      length_shift = '0;
      bytes_left = '0;
      block_position = '0;
      key_reg = '0;
      block_sum = '0;
      check_low = '0;
      error_count = 0;
    endfunction

    function krdc_pkg::res_t decode_byte(logic [7:0] b);
      krdc_pkg::res_t r;
      logic [7:0] p;
      logic [28:0] size;
      logic [15:0] chk;
      r = '0;
      r.event_res = krdc_pkg::EV_HEADER_BYTE;
      case (phase)
        PH_HEADER: begin
          length_shift = {b, length_shift[31:8]};
          if (header_count != krdc_pkg::HDR_LAST) begin
            header_count = header_count + 3'd1;
          end else begin
            header_count = '0;
            size = 29'((length_shift ^ krdc_pkg::LEN_XOR) >> 3);
            bytes_left = size;
            key_reg = start_key;
            block_sum = '0;
            block_position = '0;
            phase = (size == 0) ? PH_HEADER : PH_DATA;
            r.event_res = krdc_pkg::EV_HEADER_DONE;
            r.record_size = size;
            r.end_of_record = (size == 0);
          end
        end
        PH_DATA: begin
          p = b ^ key_reg[7:0];
          block_sum = block_sum + 16'(p) * 16'(krdc_pkg::BLOCK_LEN - block_position);
          key_reg = ~((key_reg << 1) + krdc_pkg::KEY_ADD + {31'd0, key_reg[15]});
          bytes_left = bytes_left - 29'd1;
          r.event_res = krdc_pkg::EV_DATA_BYTE;
          r.plain_byte = p;
          if (block_position == 5'(krdc_pkg::BLOCK_LEN - 1)) begin
            block_position = '0;
            phase = PH_CHK_LO;
          end else begin
            block_position = block_position + 5'd1;
            if (bytes_left == 0) begin
              phase = PH_HEADER;
              r.end_of_record = 1'b1;
            end
          end
        end
        PH_CHK_LO: begin
          check_low = b;
          phase = PH_CHK_HI;
          r.event_res = krdc_pkg::EV_CHECK_BYTE;
        end
        default: begin
          chk = {b, check_low};
          if (chk != block_sum) begin
            phase = PH_HEADER;
            bytes_left = '0;
            r.event_res = krdc_pkg::EV_CHECK_FAIL;
          end else begin
            r.event_res = krdc_pkg::EV_CHECK_OK;
            if (bytes_left == 0) begin
              phase = PH_HEADER;
              r.end_of_record = 1'b1;
            end else begin
              phase = PH_DATA;
            end
          end
          block_sum = '0;
          block_position = '0;
        end
      endcase
      return r;
    endfunction

    function void note_raw_byte(logic [7:0] b);
      pending_results = {pending_results, decode_byte(b)};
    endfunction

    function void report(string what, krdc_pkg::res_t want, krdc_pkg::res_t got);
      error_count++;
      if (error_count <= 10)
        $display("[%0t] %s: want ev=%0d pb=%02h sz=%0d eor=%0d, got ev=%0d pb=%02h sz=%0d eor=%0d",
                 $time, what, want.event_res, want.plain_byte, want.record_size,
                 want.end_of_record, got.event_res, got.plain_byte, got.record_size,
                 got.end_of_record);
    endfunction

    function void check_result(krdc_pkg::res_t got);
      krdc_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.event_res !== want.event_res || got.plain_byte !== want.plain_byte ||
            got.record_size !== want.record_size || got.end_of_record !== want.end_of_record)
          report("mismatch", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  krdc_in_if  in_ch();
  krdc_out_if out_ch();
  krdc_cfg_if cfg();

  keystream_record_decrypt_check dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  record_tracker tracker = new();
  record_tracker planner = new();

  logic [7:0]  raw_stream[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && hold_count < HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      tracker.note_raw_byte(in_ch.raw_byte);
  end

  always @(posedge clk) begin : take_result
    krdc_pkg::res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.event_res = krdc_pkg::event_t'(out_ch.event_res);
      got.plain_byte = out_ch.plain_byte;
      got.record_size = out_ch.record_size;
      got.end_of_record = out_ch.end_of_record;
      tracker.check_result(got);
    end
  end

  function automatic void queue_byte(logic [7:0] b);
    void'(planner.decode_byte(b));
    raw_stream = {raw_stream, b};
  endfunction

  function automatic void queue_dword(logic [31:0] d);
    for (int i = 0; i < 4; i++)
      queue_byte(d[8*i +: 8]);
  endfunction

  function automatic void queue_header(logic [28:0] len);
    queue_dword($urandom);
    queue_dword({len, 3'($urandom_range(7))} ^ krdc_pkg::LEN_XOR);
  endfunction

  // runs the planner back to the start of a header; forces a bad check once cut is reached, or at random with bad_pct
  function automatic void complete_record(int unsigned bad_pct, int unsigned cut);
    int unsigned data_seen;
    logic [15:0] flip;
    data_seen = 0;
    flip = '0;
    while (!(planner.phase == PH_HEADER && planner.header_count == 0)) begin
      case (planner.phase)
        PH_HEADER: queue_byte(8'($urandom));
        PH_DATA: begin
          queue_byte(8'($urandom) ^ planner.key_reg[7:0]);
          data_seen++;
        end
        PH_CHK_LO: begin
          flip = '0;
          if (data_seen >= cut || $urandom_range(99) < bad_pct)
            flip = 16'($urandom_range(65535, 1));
          queue_byte(planner.block_sum[7:0] ^ flip[7:0]);
        end
        default: queue_byte(planner.block_sum[15:8] ^ flip[15:8]);
      endcase
    end
  endfunction

  function automatic void plan_records(int unsigned count);
    int unsigned kind;
    complete_record(3, 1000);
    while (raw_stream.size() < count) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        queue_header(29'($urandom_range(80, 1)));
        complete_record(3, 1000);
      end else if (kind < 70) begin
        queue_header(29'(32 * $urandom_range(3, 1)));
        complete_record(2, 1000);
      end else if (kind < 78) begin
        queue_header('0);
      end else if (kind < 85) begin
        queue_header(29'($urandom));
        complete_record(0, $urandom_range(64));
      end else if (kind < 92) begin
        queue_header(29'($urandom_range(96, 33)));
        complete_record(100, 1000);
      end else begin
        repeat ($urandom_range(24, 1)) queue_byte(8'($urandom));
        complete_record(0, 64);
      end
    end
  endfunction

  task automatic send_bytes();
    while (raw_stream.size() > 0) begin
      if ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.raw_byte <= raw_stream.pop_front();
        do @(posedge clk); while (!in_ch.ready);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_start_key(logic [31:0] key);
    cfg.valid <= 1'b1;
    cfg.start_key <= key;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    tracker.start_key = key;
    planner.start_key = key;
  endtask

  task automatic run_phase(logic [31:0] key, int unsigned tx_idle, int unsigned rx_idle,
                           int unsigned count);
    write_start_key(key);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    plan_records(count);
    send_bytes();
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_byte = '0;
    cfg.valid = 1'b0;
    cfg.start_key = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_start_key(32'hffff_ffff);
    // empty record, then a one-byte record with plain byte ff
    queue_dword(32'h0000_0000);
    queue_dword({29'd0, 3'b111} ^ krdc_pkg::LEN_XOR);
    queue_dword(32'hffff_ffff);
    queue_dword({29'd1, 3'b000} ^ krdc_pkg::LEN_XOR);
    queue_byte(8'hff ^ planner.key_reg[7:0]);
    // stop inside a record so the next key write lands mid-record
    queue_header(29'd2);
    queue_byte(8'h00 ^ planner.key_reg[7:0]);
    send_bytes();
    drain();

    run_phase(32'h0000_0000, 23, 50, 600);
    run_phase($urandom, 50, 23, 600);
    run_phase($urandom, 0, 0, 600);

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_start_key(32'h8000_7fff);
    plan_records(150);
    hold_go <= 1'b1;
    send_bytes();
    drain();

    repeat (10) @(posedge clk);
    if (tracker.error_count == 0 && tracker.pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- keystream_record_decrypt_check.f -----
hdl/krdc_pkg.sv
hdl/krdc_if.sv
hdl/krdc_core.sv
hdl/keystream_record_decrypt_check.sv
verif/keystream_record_decrypt_check_tb.sv
